/* hdl/mipbox_pkg.sv */
// ----------------------------------------------------------------------------
// mipbox_pkg
// Shared types, constants and helpers of the RGBA mip chain box downsampler.
// ----------------------------------------------------------------------------
package mipbox_pkg;

   localparam int MAX_DIM_DEF    = 4096;
   localparam int MAX_LEVELS_DEF = 13;

   localparam int CSR_DIM_W = 13;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GENERATE_MIPS = 2'd2;

   // A pixel is held as four 10-bit lanes so that sums of four values fit.
   localparam int LANE_W = 10;
   localparam int PIX_W  = 4 * LANE_W;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [3:0]  level;
      logic [11:0] column;
      logic [11:0] line;
      logic [7:0]  red_out;
      logic [7:0]  green_out;
      logic [7:0]  blue_out;
      logic [7:0]  alpha_out;
      logic        last;
   } rsp_type;

   // Divide each lane by four, rounding down.
   function automatic logic [PIX_W-1:0] quarter(input logic [PIX_W-1:0] s);
      logic [PIX_W-1:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[LANE_W*i +: LANE_W] = {2'b00, s[LANE_W*i+2 +: LANE_W-2]};
      end
      return r;
   endfunction

endpackage

/* hdl/rgba_mip_chain_box_downsampler_unit.sv */
// ----------------------------------------------------------------------------
// rgba_mip_chain_box_downsampler_unit
// Streams level-0 RGBA8 pixels through and builds the mip chain with a 2x2
// box filter, using one line store of partial row sums shared by all levels.
// ----------------------------------------------------------------------------
// An item is taken in S_IDLE, and an S_LEVEL step registers its level-0
// result into the output register. Each further level takes another S_LEVEL
// step, plus an S_READ step when that level reads the line store (odd rows);
// an output stall holds the S_LEVEL steps. Only one item is in work at a time:
// no new pixel is taken until the last one has gone from S_LEVEL to S_IDLE.
// Reset clears control state, counters and registers (width 1, height 1,
// mips on); the line store is not cleared since rows are written before use.
module rgba_mip_chain_box_downsampler_unit #(
   parameter int MAX_DIM    = mipbox_pkg::MAX_DIM_DEF,
   parameter int MAX_LEVELS = mipbox_pkg::MAX_LEVELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mipbox_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mipbox_pkg::rsp_type                 rsp_data,
   input  logic                                csr_we,
   input  logic [mipbox_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mipbox_pkg::CSR_DIM_W-1:0]    csr_wdata
);

   localparam int CW  = $clog2(MAX_DIM);        // coordinate counter width
   localparam int DW  = $clog2(MAX_DIM + 1);    // dimension width
   localparam int BW  = DW + 1;                 // line store region offset width
   localparam int LIW = $clog2(MAX_LEVELS);     // level index width
   localparam int NW  = $clog2(DW + 2);         // level count width
   localparam int PW  = mipbox_pkg::PIX_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LEVEL,
      S_READ
   } state_type;

   // Configuration.
   logic [DW-1:0] img_w_ff, img_h_ff;
   logic          gen_ff;
   logic [DW-1:0] csr_dim;

   // Control.
   state_type      state_ff;
   logic [LIW-1:0] lvl_ff;
   logic [DW-1:0]  wl_ff, hl_ff;
   logic [BW-1:0]  base_ff;
   logic           end_ff;
   logic           rsp_valid_ff;
   logic [CW-1:0]  col_ff [MAX_LEVELS];
   logic [CW-1:0]  row_ff [MAX_LEVELS];

   // Payload.
   logic [PW-1:0]       cur_ff, pair_ff;
   logic [PW-1:0]       held_ff [MAX_LEVELS];
   logic                oob_ff;
   mipbox_pkg::rsp_type rsp_data_ff;

   // Level count of the chain.
   logic [DW-1:0] md;
   logic [NW-1:0] lg, n_raw, n_lvls;

   always_comb begin
      md = (img_w_ff > img_h_ff) ? img_w_ff : img_h_ff;
      lg = '0;
      for (int i = 0; i < DW; i++) begin
         if (md[i]) begin
            lg = NW'(i);
         end
      end
      n_raw = lg + NW'(1);
      if (!gen_ff) begin
         n_lvls = NW'(1);
      end else if (int'(n_raw) > MAX_LEVELS) begin
         n_lvls = NW'(MAX_LEVELS);
      end else begin
         n_lvls = n_raw;
      end
   end

   // A size register is clamped to 1 .. MAX_DIM.
   always_comb begin
      if (csr_wdata == '0) begin
         csr_dim = DW'(1);
      end else if (int'(csr_wdata) > MAX_DIM) begin
         csr_dim = DW'(MAX_DIM);
      end else begin
         csr_dim = DW'(csr_wdata);
      end
   end

   // One level step in S_LEVEL: emit the pixel, then decide whether it
   // completes anything at the next level.
   logic [CW-1:0] x, y;
   logic          slot_free, top_lvl, hold_x, park_y, stop, need_rd;
   logic [PW-1:0] pair;
   logic [BW-1:0] idx;
   logic          idx_ok;
   logic [DW-1:0] w_next, h_next;
   logic [DW-1:0] x_inc, y_inc;
   logic [PW-1:0] rd_data;

   always_comb begin
      x         = col_ff[lvl_ff];
      y         = row_ff[lvl_ff];
      slot_free = !rsp_valid_ff || !rsp_stall;
      top_lvl   = (NW'(lvl_ff) + NW'(1)) >= n_lvls;
      hold_x    = (wl_ff != DW'(1)) && !x[0];
      park_y    = (hl_ff != DW'(1)) && !y[0];
      stop      = top_lvl || hold_x || park_y;
      need_rd   = !stop && (hl_ff != DW'(1));
      pair      = (wl_ff == DW'(1)) ? cur_ff + cur_ff : held_ff[lvl_ff] + cur_ff;
      idx       = base_ff + ((wl_ff == DW'(1)) ? BW'(0) : BW'(x >> 1));
      idx_ok    = int'(idx) < MAX_DIM;
      w_next    = (wl_ff >> 1) == '0 ? DW'(1) : wl_ff >> 1;
      h_next    = (hl_ff >> 1) == '0 ? DW'(1) : hl_ff >> 1;
      x_inc     = DW'(x) + DW'(1);
      y_inc     = DW'(y) + DW'(1);
   end

   logic step;
   assign step = (state_ff == S_LEVEL) && slot_free;

   // All counters restart on a register write and after the last pixel of
   // an image has gone through its whole chain.
   logic clear_cnt;
   assign clear_cnt = (csr_we && (csr_index == mipbox_pkg::CSR_IMAGE_WIDTH ||
                                  csr_index == mipbox_pkg::CSR_IMAGE_HEIGHT ||
                                  csr_index == mipbox_pkg::CSR_GENERATE_MIPS)) ||
                      (step && stop && end_ff);

   mipbox_line_store #(
      .DEPTH (MAX_DIM),
      .WIDTH (PW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (step && !top_lvl && !hold_x && park_y && idx_ok),
      .wr_addr (idx[$clog2(MAX_DIM)-1:0]),
      .wr_data (pair),
      .rd_en   (step && need_rd),
      .rd_addr (idx[$clog2(MAX_DIM)-1:0]),
      .rd_data (rd_data)
   );

   // Control registers and level counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         img_w_ff     <= DW'(1);
         img_h_ff     <= DW'(1);
         gen_ff       <= 1'b1;
         lvl_ff       <= '0;
         wl_ff        <= DW'(1);
         hl_ff        <= DW'(1);
         base_ff      <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else begin
         if (slot_free) begin
            rsp_valid_ff <= step;
         end
         if (csr_we) begin
            case (csr_index)
               mipbox_pkg::CSR_IMAGE_WIDTH: begin
                  img_w_ff <= csr_dim;
               end
               mipbox_pkg::CSR_IMAGE_HEIGHT: begin
                  img_h_ff <= csr_dim;
               end
               mipbox_pkg::CSR_GENERATE_MIPS: begin
                  gen_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (clear_cnt) begin
            for (int i = 0; i < MAX_LEVELS; i++) begin
               col_ff[i] <= '0;
               row_ff[i] <= '0;
            end
         end else if (step) begin
            if (x_inc >= wl_ff) begin
               col_ff[lvl_ff] <= '0;
               row_ff[lvl_ff] <= (y_inc >= hl_ff) ? '0 : CW'(y_inc);
            end else begin
               col_ff[lvl_ff] <= CW'(x_inc);
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_LEVEL;
                  lvl_ff   <= '0;
                  wl_ff    <= img_w_ff;
                  hl_ff    <= img_h_ff;
                  base_ff  <= '0;
                  end_ff   <= (DW'(col_ff[0]) == img_w_ff - DW'(1)) &&
                              (DW'(row_ff[0]) == img_h_ff - DW'(1));
               end
            end
            S_LEVEL: begin
               if (slot_free) begin
                  if (stop) begin
                     state_ff <= S_IDLE;
                  end else if (need_rd) begin
                     state_ff <= S_READ;
                  end else begin
                     lvl_ff  <= lvl_ff + LIW'(1);
                     wl_ff   <= w_next;
                     hl_ff   <= h_next;
                     base_ff <= base_ff + BW'(w_next);
                  end
               end
            end
            S_READ: begin
               state_ff <= S_LEVEL;
               lvl_ff   <= lvl_ff + LIW'(1);
               wl_ff    <= w_next;
               hl_ff    <= h_next;
               base_ff  <= base_ff + BW'(w_next);
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Pixel payload and the output register.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cur_ff <= {2'b00, req_data.red_in, 2'b00, req_data.green_in,
                    2'b00, req_data.blue_in, 2'b00, req_data.alpha_in};
      end
      if (step) begin
         rsp_data_ff.level     <= 4'(lvl_ff);
         rsp_data_ff.column    <= 12'(x);
         rsp_data_ff.line      <= 12'(y);
         rsp_data_ff.red_out   <= cur_ff[3*mipbox_pkg::LANE_W +: 8];
         rsp_data_ff.green_out <= cur_ff[2*mipbox_pkg::LANE_W +: 8];
         rsp_data_ff.blue_out  <= cur_ff[mipbox_pkg::LANE_W +: 8];
         rsp_data_ff.alpha_out <= cur_ff[7:0];
         rsp_data_ff.last      <= stop && end_ff;
         pair_ff               <= pair;
         oob_ff                <= !idx_ok;
         if (!top_lvl && hold_x) begin
            held_ff[lvl_ff] <= cur_ff;
         end
         if (!stop && !need_rd) begin
            cur_ff <= mipbox_pkg::quarter(pair + pair);
         end
      end
      if (state_ff == S_READ) begin
         cur_ff <= mipbox_pkg::quarter(pair_ff + (oob_ff ? PW'(0) : rd_data));
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/mipbox_line_store.sv */
// ----------------------------------------------------------------------------
// mipbox_line_store
// Single-port-write, single-port-read line store with registered read data.
// ----------------------------------------------------------------------------
module mipbox_line_store #(
   parameter int DEPTH = mipbox_pkg::MAX_DIM_DEF,
   parameter int WIDTH = mipbox_pkg::PIX_W
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for the RGBA mip chain box downsampler. Pixels are
// streamed in raster order under random idle and stall patterns. A predictor
// in this file tracks the per-level counters, held pair sums and line store,
// and queues the expected level-0 and mip pixels that each item produces.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAXL = mipbox_pkg::MAX_LEVELS_DEF;
   localparam int MAXD = mipbox_pkg::MAX_DIM_DEF;
   localparam logic [mipbox_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int ITEM_GOAL = 190;
   localparam int ITEM_CAP = 210;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   mipbox_pkg::req_type              req_data = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   mipbox_pkg::rsp_type              rsp_data;
   logic                             csr_we = 1'b0;
   logic [mipbox_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mipbox_pkg::CSR_DIM_W-1:0] csr_wdata = '0;

   rgba_mip_chain_box_downsampler_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state: a private copy of the registers and of everything the
   // block remembers between pixels.
   int unsigned cfg_width = 1;
   int unsigned cfg_height = 1;
   bit          cfg_mips = 1'b1;
   int unsigned col_cnt[MAXL];
   int unsigned row_cnt[MAXL];
   logic [39:0] held_sum[MAXL];
   logic [39:0] row_store[MAXD];

   mipbox_pkg::rsp_type expected_pixels[$];
   int          errors = 0;
   int          pixels_sent = 0;
   bit          no_idle = 1'b0;
   int          hold_request = 0;
   int          hold_left = 0;
   int          stall_left = 0;
   int          quiet_cycles = 0;

   initial begin
      for (int i = 0; i < MAXL; i++) begin
         col_cnt[i] = 0;
         row_cnt[i] = 0;
         held_sum[i] = '0;
      end
   end

   function automatic void clear_counts();
      for (int i = 0; i < MAXL; i++) begin
         col_cnt[i] = 0;
         row_cnt[i] = 0;
      end
   endfunction

   function automatic int unsigned clamp_size(logic [mipbox_pkg::CSR_DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAXD) return MAXD;
      return 32'(v);
   endfunction

   // Each 10-bit lane holds a sum of four 8-bit values; keep its floor / 4.
   function automatic logic [39:0] box_average(logic [39:0] s);
      logic [39:0] q;
      q = '0;
      for (int i = 0; i < 4; i++) q[10*i +: 10] = s[10*i +: 10] >> 2;
      return q;
   endfunction

   // Work out every pixel that one level-0 input completes, lowest level
   // first, and append them to the expected queue.
   function automatic void predict_mips(mipbox_pkg::req_type p);
      int unsigned wl[MAXL];
      int unsigned hl[MAXL];
      int unsigned base[MAXL+1];
      int unsigned n, md, lv, x, y, dx, idx;
      logic [39:0] cur, pair, total;
      bit          at_end, done;
      mipbox_pkg::rsp_type r;
      wl[0] = cfg_width;
      hl[0] = cfg_height;
      md = (wl[0] > hl[0]) ? wl[0] : hl[0];
      n = 1;
      while (md > 1) begin
         md = md >> 1;
         n++;
      end
      if (n > MAXL) n = MAXL;
      if (!cfg_mips) n = 1;
      base[0] = 0;
      base[1] = 0;
      for (lv = 1; lv < n; lv++) begin
         wl[lv] = (wl[lv-1] >> 1 == 0) ? 1 : wl[lv-1] >> 1;
         hl[lv] = (hl[lv-1] >> 1 == 0) ? 1 : hl[lv-1] >> 1;
         base[lv+1] = base[lv] + wl[lv];
      end
      at_end = (col_cnt[0] == wl[0] - 1) && (row_cnt[0] == hl[0] - 1);
      cur = {2'b00, p.alpha_in, 2'b00, p.blue_in, 2'b00, p.green_in, 2'b00, p.red_in};
      lv = 0;
      done = 1'b0;
      pair = '0;
      total = '0;
      dx = 0;
      while (!done) begin
         x = col_cnt[lv];
         y = row_cnt[lv];
         r.level = 4'(lv);
         r.column = 12'(x);
         r.line = 12'(y);
         r.red_out = cur[7:0];
         r.green_out = cur[17:10];
         r.blue_out = cur[27:20];
         r.alpha_out = cur[37:30];
         r.last = 1'b0;
         expected_pixels.push_back(r);
         col_cnt[lv] = x + 1;
         if (col_cnt[lv] >= wl[lv]) begin
            col_cnt[lv] = 0;
            row_cnt[lv] = (y + 1 >= hl[lv]) ? 0 : y + 1;
         end
         if (lv + 1 >= n) begin
            done = 1'b1;
         end else if (wl[lv] == 1) begin
            // A single column is paired with itself.
            pair = cur + cur;
            dx = 0;
         end else if (x[0] == 1'b0) begin
            held_sum[lv] = cur;
            done = 1'b1;
         end else begin
            pair = held_sum[lv] + cur;
            dx = x >> 1;
         end
         if (!done) begin
            if (hl[lv] == 1) begin
               total = pair + pair;
            end else begin
               idx = base[lv+1] + dx;
               if (y[0] == 1'b0) begin
                  if (idx < MAXD) row_store[idx] = pair;
                  done = 1'b1;
               end else begin
                  total = pair + ((idx < MAXD) ? row_store[idx] : 40'd0);
               end
            end
         end
         if (!done) begin
            cur = box_average(total);
            lv++;
         end
      end
      if (at_end) begin
         r = expected_pixels.pop_back();
         r.last = 1'b1;
         expected_pixels.push_back(r);
         clear_counts();
      end
   endfunction

   // Sends one pixel after a random gap. On acceptance valid is left high, so
   // a following pixel with no gap is offered straight away.
   task automatic send_pixel(mipbox_pkg::req_type p);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (req_stall);
      predict_mips(p);
      pixels_sent++;
   endtask

   function automatic mipbox_pkg::req_type random_pixel();
      mipbox_pkg::req_type p;
      p = mipbox_pkg::req_type'($urandom);
      return p;
   endfunction

   // Lowers valid and waits until every queued pixel has come out.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [mipbox_pkg::CSR_IDX_W-1:0] idx,
                            logic [mipbox_pkg::CSR_DIM_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         mipbox_pkg::CSR_IMAGE_WIDTH: begin
            cfg_width = clamp_size(v);
            clear_counts();
         end
         mipbox_pkg::CSR_IMAGE_HEIGHT: begin
            cfg_height = clamp_size(v);
            clear_counts();
         end
         mipbox_pkg::CSR_GENERATE_MIPS: begin
            cfg_mips = v[0];
            clear_counts();
         end
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   task automatic set_image(logic [mipbox_pkg::CSR_DIM_W-1:0] w,
                            logic [mipbox_pkg::CSR_DIM_W-1:0] h, bit mips);
      drain();
      csr_write(mipbox_pkg::CSR_IMAGE_WIDTH, w);
      csr_write(mipbox_pkg::CSR_IMAGE_HEIGHT, h);
      csr_write(mipbox_pkg::CSR_GENERATE_MIPS, {{(mipbox_pkg::CSR_DIM_W-1){1'b0}}, mips});
   endtask

   task automatic send_image(int count);
      for (int i = 0; i < count; i++) send_pixel(random_pixel());
   endtask

   // Reset values give a 1x1 image: every pixel is its own whole chain and
   // carries last. Channel extremes and alternating bit patterns go here.
   task automatic test_reset_single_pixel();
      send_pixel('0);
      send_pixel('1);
      send_pixel({4{8'h55}});
      send_pixel({4{8'hAA}});
   endtask

   // Small shapes: even and odd sizes, a single row or column, and a zero
   // size register that must read as one.
   task automatic test_small_shapes();
      mipbox_pkg::req_type p;
      set_image(2, 2, 1'b1);
      send_pixel('1);
      send_pixel('1);
      send_pixel('1);
      send_pixel({8'hFF, 8'h00, 8'hFF, 8'h03});
      set_image(3, 3, 1'b1);
      send_image(9);
      set_image(1, 4, 1'b1);
      send_image(4);
      set_image(4, 1, 1'b1);
      send_image(4);
      set_image(0, 0, 1'b1);
      p = random_pixel();
      send_pixel(p);
   endtask

   task automatic test_level0_only();
      set_image(4, 3, 1'b0);
      send_image(12);
      // A write to an index with no register behind it changes nothing.
      drain();
      csr_write(CSR_UNUSED, '1);
      send_image(2);
   endtask

   // Oversize registers clamp to the largest image; only the first pixels of
   // each are sent, and the next register write restarts the counters.
   task automatic test_largest_sizes();
      set_image('1, 13'd1, 1'b1);
      send_image(12);
      set_image(13'd1, 13'd4096, 1'b1);
      send_image(12);
      set_image(13'd4096, 13'd4096, 1'b1);
      send_image(6);
   endtask

   // The receiver holds off for a long stretch while pixels keep coming, so
   // the block backs up into its input; then the sender waits for the drain.
   task automatic test_backpressure();
      set_image(8, 8, 1'b1);
      no_idle = 1'b1;
      hold_request = 300;
      send_image(64);
      no_idle = 1'b0;
      drain();
      send_image(16);
   endtask

   // Mostly whole images of random shape; some are cut short by the next
   // register write, and some run with no idling at all.
   task automatic test_random_images();
      int w, h, count;
      while (pixels_sent < ITEM_GOAL) begin
         if ($urandom_range(0, 4) == 0) begin
            w = $urandom_range(13, 64);
            h = $urandom_range(1, 3);
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
         end
         set_image(13'(w), 13'(h), $urandom_range(0, 5) != 0);
         no_idle = ($urandom_range(0, 3) == 0);
         count = w * h;
         if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count);
         if (count > ITEM_CAP - pixels_sent) count = ITEM_CAP - pixels_sent;
         send_image(count);
      end
      no_idle = 1'b0;
   endtask

   // Result side: random stall per item, plus the long hold when asked.
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_valid && !rsp_stall) stall_left = no_idle ? 0 : $urandom_range(0, 7);
      end
   end

   task automatic check_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      mipbox_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %p", $time, rsp_data);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("level", 12'(want.level), 12'(rsp_data.level));
            check_field("column", want.column, rsp_data.column);
            check_field("line", want.line, rsp_data.line);
            check_field("red", 12'(want.red_out), 12'(rsp_data.red_out));
            check_field("green", 12'(want.green_out), 12'(rsp_data.green_out));
            check_field("blue", 12'(want.blue_out), 12'(rsp_data.blue_out));
            check_field("alpha", 12'(want.alpha_out), 12'(rsp_data.alpha_out));
            check_field("last", 12'(want.last), 12'(rsp_data.last));
         end
      end
   end

   // Watchdog: too long with nothing moving on either channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress, %0d items outstanding", $time,
                     expected_pixels.size());
            $display("rgba_mip_chain_box_downsampler_unit regression: fail");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_single_pixel();
      test_small_shapes();
      test_level0_only();
      test_largest_sizes();
      test_backpressure();
      test_random_images();
      drain();
      repeat (20) @(posedge clock);
      if (expected_pixels.size() != 0) errors++;
      if (errors == 0) begin
         $display("rgba_mip_chain_box_downsampler_unit regression: pass");
      end else begin
         $display("rgba_mip_chain_box_downsampler_unit regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/mipbox_pkg.sv
hdl/mipbox_line_store.sv
hdl/rgba_mip_chain_box_downsampler_unit.sv
verif/tb.sv
